### hw/rtl/mcpm_pkg.sv
// Shared types and constants for the mecanum chassis PID mixer.
package mcpm_pkg;

    localparam int unsigned ErrW   = 18;
    localparam int unsigned IntW   = 32;
    localparam int unsigned GainW  = 16;
    localparam int unsigned LimW   = 15;
    localparam int unsigned RegIdxW = 3;

    typedef enum logic [RegIdxW-1:0] {
        REG_SPEED_KP = 3'd0,
        REG_SPEED_KI = 3'd1,
        REG_SPEED_KD = 3'd2,
        REG_HOLD_KP  = 3'd3,
        REG_HOLD_KI  = 3'd4,
        REG_HOLD_KD  = 3'd5,
        REG_OFFSET   = 3'd6,
        REG_LIMIT    = 3'd7
    } t_reg_idx;

    // Scale of the stick range onto the wheel range.
    localparam int ScaleNum  = 16342;
    localparam int ScaleOff  = 660;
    localparam int ScaleBias = 8171;
    // ceil(2^42 / 1320); the quotient is (x * RecipDiv) >> RecipShift,
    // exact for every 32-bit unsigned x
    localparam logic [31:0] RecipDiv = 32'd3331853418;
    localparam int RecipShift = 42;

endpackage

### hw/rtl/mcpm_pid.sv
// One regulator step on a shared multiplier, run over several cycles.
module mcpm_pid #(
    parameter int DEADBAND = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [31:0]              i_target,
    input  logic signed [15:0]              i_meas,
    input  logic signed [mcpm_pkg::IntW-1:0] i_integ,
    input  logic signed [mcpm_pkg::ErrW-1:0] i_prev,
    input  logic signed [mcpm_pkg::GainW-1:0] i_kp,
    input  logic signed [mcpm_pkg::GainW-1:0] i_ki,
    input  logic signed [mcpm_pkg::GainW-1:0] i_kd,
    input  logic        [mcpm_pkg::LimW-1:0]  i_limit,
    output logic                            o_done,
    output logic signed [mcpm_pkg::ErrW-1:0] o_err,
    output logic signed [mcpm_pkg::IntW-1:0] o_integ,
    output logic signed [15:0]              o_out
);
    typedef enum logic [2:0] {S_IDLE, S_ERR, S_P, S_I, S_D, S_OUT} t_state;

    t_state r_state;
    logic signed [mcpm_pkg::ErrW-1:0] r_err;
    logic signed [mcpm_pkg::IntW-1:0] r_integ;
    logic signed [51:0] r_acc;
    logic signed [15:0] r_out;
    logic r_done;

    logic signed [32:0] meas_x, diff, integ_sum;
    logic signed [mcpm_pkg::ErrW-1:0] err_sat;
    logic signed [mcpm_pkg::IntW-1:0] integ_sat;
    logic signed [32:0] mul_a;
    logic signed [mcpm_pkg::GainW-1:0] mul_b;
    logic signed [48:0] prod;
    logic signed [51:0] acc_abs, q_abs;
    logic signed [51:0] q;
    logic signed [51:0] lim_x;

    always_comb begin
        meas_x = 33'(i_meas);
        if (i_meas > -16'(DEADBAND) && i_meas < 16'(DEADBAND)) meas_x = '0;
        diff = 33'(i_target) - meas_x;
        if (diff > 33'sd131071) err_sat = 18'sd131071;
        else if (diff < -33'sd131072) err_sat = -18'sd131072;
        else err_sat = diff[mcpm_pkg::ErrW-1:0];
        integ_sum = 33'(i_integ) + 33'(r_err);
        if (integ_sum > 33'sh0_7FFF_FFFF) integ_sat = 32'sh7FFF_FFFF;
        else if (integ_sum < -33'sh0_8000_0000) integ_sat = 32'sh8000_0000;
        else integ_sat = integ_sum[31:0];
        case (r_state)
            S_P: begin mul_a = 33'(r_err); mul_b = i_kp; end
            S_I: begin mul_a = 33'(r_integ); mul_b = i_ki; end
            default: begin mul_a = 33'(r_err) - 33'(i_prev); mul_b = i_kd; end
        endcase
        prod = 49'(mul_a) * 49'(mul_b);
        acc_abs = r_acc[51] ? -r_acc : r_acc;
        q_abs = acc_abs >>> 8;
        q = r_acc[51] ? -q_abs : q_abs;
        lim_x = 52'(signed'({1'b0, i_limit}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_err   <= err_sat;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_integ <= integ_sat;
                    r_acc   <= '0;
                    r_state <= S_P;
                end
                S_P: begin r_acc <= r_acc + 52'(prod); r_state <= S_I; end
                S_I: begin r_acc <= r_acc + 52'(prod); r_state <= S_D; end
                S_D: begin r_acc <= r_acc + 52'(prod); r_state <= S_OUT; end
                S_OUT: begin
                    if (q > lim_x) r_out <= lim_x[15:0];
                    else if (q < -lim_x) r_out <= 16'(-lim_x);
                    else r_out <= q[15:0];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_err   = r_err;
    assign o_integ = r_integ;
    assign o_out   = r_out;
endmodule

### hw/rtl/mecanum_chassis_pid_mixer.sv
// Top level: heading hold, mecanum mix, target scaling and wheel speed loops.
//
// Channel  Dir  Signals                                      Payload
// input    in   s_axis_tvalid/tready/tdata/tuser             sticks, angle, speeds, hold
// output   out  m_axis_tvalid/tready/tdata                   wheel commands a..d
// config   in   i_cfg_we, i_cfg_idx, i_cfg_wdata             eight registers
//
// A beat runs the heading regulator when hold is on, then per wheel one scale
// multiply, one reciprocal multiply and a regulator run on the shared PID unit
// (skipped when BYPASS_SPEED_LOOP is set), then posts the result. The next
// beat is accepted only after the posted result has been read.
// Reset is synchronous, clears all regulator state and restores config defaults.
// The input is not ready while a beat is in work or its result is unread;
// the result register holds through output stalls.
module mecanum_chassis_pid_mixer #(
    parameter int DEADBAND = 10,
    parameter bit BYPASS_SPEED_LOOP = 1'b0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // drive[10:0], strafe[21:11], spin[32:22], angle[48:33], speed a..d [112:49]
    input  logic [119:0] s_axis_tdata,
    // hold_enable
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // wheel_out_a[15:0], b[31:16], c[47:32], d[63:48]
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    typedef enum logic [2:0] {
        S_IDLE, S_HOLD, S_HWAIT, S_MUL, S_DIV, S_WPID, S_WWAIT, S_OUT
    } t_state;

    t_state r_state;
    logic signed [15:0] r_skp, r_ski, r_skd, r_hkp, r_hki, r_hkd, r_off;
    logic [14:0] r_lim;
    logic signed [31:0] r_integ [5];
    logic signed [17:0] r_prev [5];
    logic [119:0] r_in;
    logic signed [15:0] r_fb;
    logic [1:0] r_wheel;
    logic signed [31:0] r_prod;
    logic signed [31:0] r_tgt;
    logic [63:0] r_out;
    logic r_valid;

    logic signed [12:0] drv, stf, spn;
    logic signed [17:0] mix;
    logic [2:0] slot;
    logic pid_start, pid_done;
    logic signed [31:0] pid_tgt;
    logic signed [15:0] pid_meas, pid_kp, pid_ki, pid_kd, pid_out;
    logic signed [17:0] pid_err;
    logic signed [31:0] pid_integ;
    logic [31:0] absp;
    logic [63:0] qfull;
    logic [31:0] qdiv;
    logic signed [31:0] tgt_n, lim32;
    logic signed [15:0] byp;

    assign drv = 13'(signed'(r_in[10:0]));
    assign stf = 13'(signed'(r_in[21:11]));
    assign spn = 13'(signed'(r_in[32:22]));

    always_comb begin
        case (r_wheel)
            2'd0: mix = -18'(drv) + 18'(stf) + 18'(spn) + 18'(r_fb);
            2'd1: mix =  18'(drv) + 18'(stf) + 18'(spn) + 18'(r_fb);
            2'd2: mix =  18'(drv) - 18'(stf) + 18'(spn) + 18'(r_fb);
            default: mix = -18'(drv) - 18'(stf) + 18'(spn) + 18'(r_fb);
        endcase
        // Truncating divide by 1320 through a reciprocal on the magnitude.
        absp  = r_prod[31] ? 32'(-r_prod) : 32'(r_prod);
        qfull = 64'(absp) * 64'(mcpm_pkg::RecipDiv);
        qdiv  = 32'(qfull >> mcpm_pkg::RecipShift);
        tgt_n = (r_prod[31] ? -32'(qdiv) : 32'(qdiv)) - 32'(mcpm_pkg::ScaleBias);
        lim32 = 32'({1'b0, r_lim});
        if (r_tgt > lim32) byp = lim32[15:0];
        else if (r_tgt < -lim32) byp = 16'(-lim32);
        else byp = r_tgt[15:0];
        slot = (r_state == S_HOLD || r_state == S_HWAIT) ? 3'd0 : 3'(r_wheel) + 3'd1;
        pid_start = (r_state == S_HOLD) || (r_state == S_WPID);
        pid_tgt  = (slot == 3'd0) ? 32'(r_off) : r_tgt;
        pid_meas = (slot == 3'd0) ? r_in[48:33] : r_in[49 + 16*r_wheel +: 16];
        pid_kp = (slot == 3'd0) ? r_hkp : r_skp;
        pid_ki = (slot == 3'd0) ? r_hki : r_ski;
        pid_kd = (slot == 3'd0) ? r_hkd : r_skd;
    end

    mcpm_pid #(.DEADBAND(DEADBAND)) u_pid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(pid_start),
        .i_target(pid_tgt), .i_meas(pid_meas),
        .i_integ(r_integ[slot]), .i_prev(r_prev[slot]),
        .i_kp(pid_kp), .i_ki(pid_ki), .i_kd(pid_kd), .i_limit(r_lim),
        .o_done(pid_done), .o_err(pid_err), .o_integ(pid_integ), .o_out(pid_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_skp <= 16'sd256; r_ski <= '0; r_skd <= '0;
            r_hkp <= 16'sd256; r_hki <= '0; r_hkd <= '0;
            r_off <= '0; r_lim <= 15'd5000;
            for (int i = 0; i < 5; i++) begin
                r_integ[i] <= '0;
                r_prev[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (mcpm_pkg::t_reg_idx'(i_cfg_idx))
                    mcpm_pkg::REG_SPEED_KP: r_skp <= i_cfg_wdata;
                    mcpm_pkg::REG_SPEED_KI: r_ski <= i_cfg_wdata;
                    mcpm_pkg::REG_SPEED_KD: r_skd <= i_cfg_wdata;
                    mcpm_pkg::REG_HOLD_KP:  r_hkp <= i_cfg_wdata;
                    mcpm_pkg::REG_HOLD_KI:  r_hki <= i_cfg_wdata;
                    mcpm_pkg::REG_HOLD_KD:  r_hkd <= i_cfg_wdata;
                    mcpm_pkg::REG_OFFSET:   r_off <= i_cfg_wdata;
                    mcpm_pkg::REG_LIMIT:    r_lim <= i_cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (r_valid && m_axis_tready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_in    <= s_axis_tdata;
                    r_fb    <= '0;
                    r_wheel <= '0;
                    r_state <= s_axis_tuser ? S_HOLD : S_MUL;
                end
                S_HOLD:  r_state <= S_HWAIT;
                S_HWAIT: if (pid_done) begin
                    r_fb <= pid_out;
                    r_integ[0] <= pid_integ;
                    r_prev[0]  <= pid_err;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // (mix + 660) * 16342; fits well within 32 bits
                    r_prod  <= 32'(18'(mix) + 18'(mcpm_pkg::ScaleOff)) * 32'(mcpm_pkg::ScaleNum);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_tgt   <= tgt_n;
                    r_state <= BYPASS_SPEED_LOOP ? S_WWAIT : S_WPID;
                end
                S_WPID: r_state <= S_WWAIT;
                S_WWAIT: if (BYPASS_SPEED_LOOP || pid_done) begin
                    if (BYPASS_SPEED_LOOP) r_out[16*r_wheel +: 16] <= byp;
                    else begin
                        r_out[16*r_wheel +: 16] <= pid_out;
                        r_integ[slot] <= pid_integ;
                        r_prev[slot]  <= pid_err;
                    end
                    r_wheel <= r_wheel + 2'd1;
                    r_state <= (r_wheel == 2'd3) ? S_OUT : S_MUL;
                end
                S_OUT: if (!r_valid) begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_valid;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_out;
endmodule
